FILE: src/b32d_pkg.sv
package b32d_pkg;

   localparam int MaxBytesDefault = 29;
   localparam int ByteCountWidth  = 6;
   localparam int CharCountWidth  = 7;
   localparam int QueueDepth      = 4;
   localparam int QueuePtrWidth   = $clog2(QueueDepth);
   localparam int QueueCntWidth   = $clog2(QueueDepth + 1);

   localparam logic [31:0] CrcPoly = 32'hEDB88320;
   localparam logic [31:0] CrcInit = 32'hFFFFFFFF;
   localparam logic [CharCountWidth-1:0] CharCountMax = '1;
   localparam logic [CharCountWidth-1:0] LenMin = 7'd8;
   localparam logic [CharCountWidth-1:0] LenMax = 7'd64;
   localparam logic [ByteCountWidth-1:0] CheckBytes = 6'd4;

   localparam logic [7:0] CharNul  = 8'h00;
   localparam logic [7:0] CharDash = 8'h2D;

   typedef enum logic {
      KIND_BYTE   = 1'b0,
      KIND_STATUS = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type             kind;
      logic [7:0]                id_byte;
      logic                      text_ok;
      logic [ByteCountWidth-1:0] id_length;
      logic                      last_result;
   } rsp_item_type;

   // Up to two results per character, in delivery order.
   typedef struct packed {
      logic         push_first;
      logic         push_second;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   // Returns {hit, value} for the lower-case base32 alphabet, upper case folded.
   function automatic logic [5:0] b32_lookup(input logic [7:0] c);
      logic [7:0] lc;
      logic [7:0] diff;
      lc = c;
      diff = 8'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         lc = c + 8'h20;
      end
      if (lc >= 8'h61 && lc <= 8'h7A) begin
         diff = lc - 8'h61;
         return {1'b1, diff[4:0]};
      end else if (lc >= 8'h32 && lc <= 8'h37) begin
         diff = lc - 8'h32 + 8'd26;
         return {1'b1, diff[4:0]};
      end
      return 6'd0;
   endfunction

   function automatic logic [31:0] crc_byte(input logic [31:0] crc_init, input logic [7:0] b);
      logic [31:0] crc;
      crc = crc_init ^ {24'd0, b};
      for (int j = 0; j < 8; j++) begin
         crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
      end
      return crc;
   endfunction

endpackage

FILE: src/base32_crc_id_text_decoder_core.sv
// Streaming decoder for dashed base32 text identifiers guarded by a CRC-32.
// One character enters per request and one result leaves per cycle while
// rsp_ready is high; a character is held for one register stage, then
// updates the decode state and writes its results into a four-entry result
// queue, which presents them in order. A character that completes an
// identifier byte and also ends the text gives two results; the input
// pauses only while the queue has fewer than two free entries. The
// bytes of a text whose final status shows text_ok low must be discarded.
module base32_crc_id_text_decoder_core #(
   parameter int MaxBytes = b32d_pkg::MaxBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_character,
   input  logic       req_final_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_item_kind,
   output logic [7:0] rsp_id_byte,
   output logic       rsp_text_ok,
   output logic [5:0] rsp_id_length,
   output logic       rsp_last_result
);

   b32d_pkg::push_type     push;
   b32d_pkg::rsp_item_type rsp_item;
   logic                   space_ok;

   b32d_decode #(
      .MaxBytes(MaxBytes)
   ) u_decode (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_character (req_character),
      .req_final_char(req_final_char),
      .space_ok      (space_ok),
      .push          (push)
   );

   b32d_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   assign rsp_item_kind   = rsp_item.kind;
   assign rsp_id_byte     = rsp_item.id_byte;
   assign rsp_text_ok     = rsp_item.text_ok;
   assign rsp_id_length   = rsp_item.id_length;
   assign rsp_last_result = rsp_item.last_result;

   a_status_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> rsp_item_kind)
      else $error("final status not marked as status");

   a_byte_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item_kind |-> !rsp_text_ok && !rsp_last_result && rsp_id_length == 6'd0)
      else $error("identifier byte carries status fields");

   a_length_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> {26'd0, rsp_id_length} <= 32'(MaxBytes))
      else $error("identifier length beyond limit");

   a_ok_needs_byte : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_ok |-> rsp_id_length != 6'd0)
      else $error("valid text without identifier byte");

endmodule

FILE: src/b32d_decode.sv
module b32d_decode #(
   parameter int MaxBytes = b32d_pkg::MaxBytesDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_character,
   input  logic               req_final_char,
   input  logic               space_ok,
   output b32d_pkg::push_type push
);

   localparam logic [b32d_pkg::ByteCountWidth-1:0] ByteLimit =
      b32d_pkg::ByteCountWidth'(MaxBytes + 4);

   logic       stage_valid_ff;
   logic [7:0] char_ff;
   logic       final_ff;
   logic       fire;

   logic [7:0]  bit_pool_ff, bit_pool_in;
   logic [2:0]  pool_count_ff, pool_count_in;
   logic [b32d_pkg::ByteCountWidth-1:0] byte_count_ff, byte_count_in;
   logic [b32d_pkg::CharCountWidth-1:0] char_count_ff, char_count_in;
   logic [31:0] received_ff, received_in;
   logic [31:0] running_ff, running_in;
   logic        error_ff, error_in;
   logic        ended_ff, ended_in;

   logic [5:0]  lookup;
   logic [12:0] acc;
   logic [3:0]  cnt;
   logic [3:0]  cnt_rem;
   logic [7:0]  new_byte;
   logic        emit_byte;
   logic        text_ok;
   logic [b32d_pkg::ByteCountWidth-1:0] id_length;

   assign fire      = stage_valid_ff && space_ok;
   assign req_ready = !stage_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff  <= req_character;
         final_ff <= req_final_char;
      end
   end

   always_comb begin
      bit_pool_in   = bit_pool_ff;
      pool_count_in = pool_count_ff;
      byte_count_in = byte_count_ff;
      char_count_in = char_count_ff;
      received_in   = received_ff;
      running_in    = running_ff;
      error_in      = error_ff;
      ended_in      = ended_ff;
      emit_byte     = 1'b0;
      lookup        = b32d_pkg::b32_lookup(char_ff);
      acc           = {bit_pool_ff, lookup[4:0]};
      cnt           = {1'b0, pool_count_ff} + 4'd5;
      cnt_rem       = cnt - 4'd8;
      new_byte      = 8'(acc >> cnt_rem);

      if (!ended_ff) begin
         if (char_ff == b32d_pkg::CharNul) begin
            ended_in = 1'b1;
         end else if (char_ff != b32d_pkg::CharDash) begin
            if (char_count_ff != b32d_pkg::CharCountMax) begin
               char_count_in = char_count_ff + 1'b1;
            end
            if (!b32d_pkg::is_space(char_ff) && !error_ff) begin
               if (!lookup[5]) begin
                  error_in = 1'b1;
               end else if (cnt >= 4'd8) begin
                  // A full byte leaves the pool; the remainder stays right aligned.
                  bit_pool_in   = 8'(acc & ((13'd1 << cnt_rem) - 13'd1));
                  pool_count_in = cnt_rem[2:0];
                  if (byte_count_ff >= ByteLimit) begin
                     error_in = 1'b1;
                  end else begin
                     if (byte_count_ff < b32d_pkg::CheckBytes) begin
                        received_in = {received_ff[23:0], new_byte};
                     end else begin
                        running_in = b32d_pkg::crc_byte(running_ff, new_byte);
                        emit_byte  = 1'b1;
                     end
                     byte_count_in = byte_count_ff + 1'b1;
                  end
               end else begin
                  bit_pool_in   = acc[7:0];
                  pool_count_in = cnt[2:0];
               end
            end
         end
      end

      text_ok = !error_in
             && char_count_in >= b32d_pkg::LenMin && char_count_in <= b32d_pkg::LenMax
             && byte_count_in > b32d_pkg::CheckBytes
             && bit_pool_in == 8'd0
             && received_in == ~running_in;
      id_length = (byte_count_in >= b32d_pkg::CheckBytes) ?
                  byte_count_in - b32d_pkg::CheckBytes : '0;
   end

   always_comb begin
      push = '0;
      if (fire) begin
         if (emit_byte) begin
            push.push_first         = 1'b1;
            push.first.kind         = b32d_pkg::KIND_BYTE;
            push.first.id_byte      = new_byte;
            push.push_second        = final_ff;
            push.second.kind        = b32d_pkg::KIND_STATUS;
            push.second.text_ok     = text_ok;
            push.second.id_length   = id_length;
            push.second.last_result = 1'b1;
         end else if (final_ff) begin
            push.push_first        = 1'b1;
            push.first.kind        = b32d_pkg::KIND_STATUS;
            push.first.text_ok     = text_ok;
            push.first.id_length   = id_length;
            push.first.last_result = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && final_ff)) begin
         bit_pool_ff   <= '0;
         pool_count_ff <= '0;
         byte_count_ff <= '0;
         char_count_ff <= '0;
         received_ff   <= '0;
         running_ff    <= b32d_pkg::CrcInit;
         error_ff      <= 1'b0;
         ended_ff      <= 1'b0;
      end else if (fire) begin
         bit_pool_ff   <= bit_pool_in;
         pool_count_ff <= pool_count_in;
         byte_count_ff <= byte_count_in;
         char_count_ff <= char_count_in;
         received_ff   <= received_in;
         running_ff    <= running_in;
         error_ff      <= error_in;
         ended_ff      <= ended_in;
      end
   end

endmodule

FILE: src/b32d_rsp_queue.sv
module b32d_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  b32d_pkg::push_type     push,
   output logic                   space_ok,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output b32d_pkg::rsp_item_type rsp_item
);

   b32d_pkg::rsp_item_type entry_ff [b32d_pkg::QueueDepth];

   logic [b32d_pkg::QueuePtrWidth-1:0] head_ff, head_in;
   logic [b32d_pkg::QueuePtrWidth-1:0] tail_ff, tail_in;
   logic [b32d_pkg::QueueCntWidth-1:0] count_ff, count_in;
   logic [b32d_pkg::QueuePtrWidth-1:0] tail_next;
   logic                               pop;
   logic [1:0]                         push_count;

   assign rsp_valid  = count_ff != '0;
   assign rsp_item   = entry_ff[head_ff];
   assign pop        = rsp_valid && rsp_ready;
   // Two free entries are needed since one character can yield two results.
   assign space_ok   = count_ff <= b32d_pkg::QueueCntWidth'(b32d_pkg::QueueDepth - 2);
   assign push_count = {1'b0, push.push_first} + {1'b0, push.push_second};
   assign tail_next  = tail_ff + 1'b1;

   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = tail_ff + b32d_pkg::QueuePtrWidth'(push_count);
      count_in = count_ff + b32d_pkg::QueueCntWidth'(push_count)
               - b32d_pkg::QueueCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_first) begin
         entry_ff[tail_ff] <= push.first;
      end
      if (push.push_second) begin
         entry_ff[tail_next] <= push.second;
      end
   end

endmodule

FILE: tb/base32_crc_id_text_decoder_core_tb.sv
`timescale 1ns / 1ps

module base32_crc_id_text_decoder_core_tb;
   import b32d_pkg::*;

   localparam int MaxIdBytes = MaxBytesDefault;
   localparam int CharTarget = 1050;
   localparam int CycleLimit = 400000;
   localparam int LongHold   = 300;

   typedef enum int {
      FLAW_NONE,
      FLAW_CHAR,
      FLAW_CRC,
      FLAW_PAD,
      FLAW_SPACE,
      FLAW_CUT,
      FLAW_NUL
   } flaw_type;

   class id_text_scoreboard;
      logic [7:0]   pool;
      logic [2:0]   pool_bits;
      logic [5:0]   byte_total;
      logic [6:0]   char_total;
      logic [31:0]  crc_received;
      logic [31:0]  crc_running;
      bit           bad_seen;
      bit           nul_seen;
      rsp_item_type expected_q[$];
      int           mismatches;
      int           checked;
      int           texts_ok;

      function new();
         mismatches = 0;
         checked    = 0;
         texts_ok   = 0;
         clear_text();
      endfunction

      function void clear_text();
         pool         = '0;
         pool_bits    = '0;
         byte_total   = '0;
         char_total   = '0;
         crc_received = '0;
         crc_running  = CrcInit;
         bad_seen     = 1'b0;
         nul_seen     = 1'b0;
      endfunction

      static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
         logic [31:0] r;
         r = crc ^ {24'd0, b};
         for (int k = 0; k < 8; k++) begin
            r = {1'b0, r[31:1]} ^ (r[0] ? CrcPoly : 32'd0);
         end
         return r;
      endfunction

      static function int b32_code(logic [7:0] c);
         if (c >= "a" && c <= "z") begin
            return int'(c) - int'("a");
         end
         if (c >= "A" && c <= "Z") begin
            return int'(c) - int'("A");
         end
         if (c >= "2" && c <= "7") begin
            return int'(c) - int'("2") + 26;
         end
         return -1;
      endfunction

      static function bit is_blank(logic [7:0] c);
         return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
      endfunction

      // Works out the results of one accepted character request.
      function void note_char(logic [7:0] c, bit fin);
         int           code;
         int           nbits;
         logic [12:0]  acc;
         logic [7:0]   b;
         rsp_item_type item;
         if (!nul_seen) begin
            if (c == CharNul) begin
               nul_seen = 1'b1;
            end else if (c != CharDash) begin
               if (char_total != CharCountMax) begin
                  char_total++;
               end
               code = b32_code(c);
               if (!is_blank(c) && !bad_seen) begin
                  if (code < 0) begin
                     bad_seen = 1'b1;
                  end else begin
                     acc   = {pool, code[4:0]};
                     nbits = int'(pool_bits) + 5;
                     if (nbits >= 8) begin
                        nbits -= 8;
                        b   = 8'(acc >> nbits);
                        acc = acc & ((13'd1 << nbits) - 13'd1);
                        if (int'(byte_total) >= MaxIdBytes + 4) begin
                           bad_seen = 1'b1;
                        end else begin
                           if (byte_total < CheckBytes) begin
                              crc_received = {crc_received[23:0], b};
                           end else begin
                              crc_running = crc_step(crc_running, b);
                              item = '0;
                              item.kind = KIND_BYTE;
                              item.id_byte = b;
                              expected_q.push_back(item);
                           end
                           byte_total++;
                        end
                     end
                     pool      = acc[7:0];
                     pool_bits = 3'(nbits);
                  end
               end
            end
         end
         if (fin) begin
            item = '0;
            item.kind = KIND_STATUS;
            item.last_result = 1'b1;
            item.text_ok = !bad_seen && char_total >= LenMin && char_total <= LenMax
                           && byte_total > CheckBytes && pool == 8'd0
                           && crc_received == ~crc_running;
            item.id_length = (byte_total >= CheckBytes) ? byte_total - CheckBytes : '0;
            if (item.text_ok) begin
               texts_ok++;
            end
            expected_q.push_back(item);
            clear_text();
         end
      endfunction

      function void report(string what, rsp_item_type want, rsp_item_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%s: expected kind %0d byte %02h ok %0d len %0d last %0d,",
                     what, want.kind, want.id_byte, want.text_ok, want.id_length,
                     want.last_result);
            $display("   got kind %0d byte %02h ok %0d len %0d last %0d",
                     got.kind, got.id_byte, got.text_ok, got.id_length, got.last_result);
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         checked++;
         if (expected_q.size() == 0) begin
            report("result with nothing pending", '0, got);
         end else begin
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.id_byte !== want.id_byte
                || got.text_ok !== want.text_ok || got.id_length !== want.id_length
                || got.last_result !== want.last_result) begin
               report("result mismatch", want, got);
            end
         end
      endfunction

      function void check_drained();
         while (expected_q.size() != 0) begin
            report("result never delivered", expected_q.pop_front(), '0);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_character;
   logic       req_final_char;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_item_kind;
   logic [7:0] rsp_id_byte;
   logic       rsp_text_ok;
   logic [5:0] rsp_id_length;
   logic       rsp_last_result;

   id_text_scoreboard board = new();
   rsp_item_type      seen_item;
   logic [7:0]        text_buf[$];
   int                cycle_count = 0;
   int                chars_sent = 0;
   int                texts_sent = 0;
   bit                no_gaps = 1'b0;
   bit                random_phase = 1'b0;
   bit                long_hold_done = 1'b0;

   base32_crc_id_text_decoder_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_character  (req_character),
      .req_final_char (req_final_char),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item_kind  (rsp_item_kind),
      .rsp_id_byte    (rsp_id_byte),
      .rsp_text_ok    (rsp_text_ok),
      .rsp_id_length  (rsp_id_length),
      .rsp_last_result(rsp_last_result)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("base32_crc_id_text_decoder_core_tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_item.kind        = item_kind_type'(rsp_item_kind);
         seen_item.id_byte     = rsp_id_byte;
         seen_item.text_ok     = rsp_text_ok;
         seen_item.id_length   = rsp_id_length;
         seen_item.last_result = rsp_last_result;
         board.check_result(seen_item);
      end
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   initial begin
      int hold;
      int run;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (random_phase && !long_hold_done) begin
            // Hold results back long enough that the input side backs up.
            long_hold_done = 1'b1;
            hold = LongHold;
         end else begin
            hold = pick_gap();
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
         repeat (run) @(posedge clock);
      end
   end

   task automatic send_char(input logic [7:0] c, input bit fin);
      int gap;
      req_valid      <= 1'b1;
      req_character  <= c;
      req_final_char <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_char(c, fin);
      chars_sent++;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text();
      no_gaps = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < text_buf.size(); i++) begin
         send_char(text_buf[i], i == text_buf.size() - 1);
      end
      texts_sent++;
   endtask

   function automatic logic [7:0] pick_blank();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
   endfunction

   function automatic logic [7:0] letter_of(int code);
      if (code < 26) begin
         return ($urandom_range(0, 3) == 0) ? 8'("A" + code) : 8'("a" + code);
      end
      return 8'("2" + code - 26);
   endfunction

   // Encodes a random identifier with its checksum in front, then applies one flaw.
   task automatic build_id_text(input int n_id, input flaw_type flaw);
      logic [7:0]  packed_bytes[$];
      logic [7:0]  b;
      logic [31:0] crc;
      int          total_bits;
      int          groups;
      int          pad;
      int          code;
      int          k;
      int          pos;
      bit          dashed;
      crc = CrcInit;
      packed_bytes = {};
      for (int i = 0; i < n_id; i++) begin
         b = 8'($urandom);
         packed_bytes.push_back(b);
         crc = id_text_scoreboard::crc_step(crc, b);
      end
      crc = ~crc;
      for (int i = 0; i < 4; i++) begin
         packed_bytes.push_front(crc[5'(8*i) +: 8]);
      end
      if (flaw == FLAW_CRC) begin
         pos = $urandom_range(0, packed_bytes.size() - 1);
         packed_bytes[pos][3'($urandom_range(0, 7))] ^= 1'b1;
      end
      total_bits = 8 * packed_bytes.size();
      groups = (total_bits + 4) / 5;
      pad = groups * 5 - total_bits;
      dashed = 1'($urandom_range(0, 1));
      text_buf = {};
      for (int g = 0; g < groups; g++) begin
         code = 0;
         for (int j = 0; j < 5; j++) begin
            k = 5 * g + j;
            code = code * 2 + ((k < total_bits) ?
                               int'(packed_bytes[k / 8][3'(7 - k % 8)]) : 0);
         end
         if (flaw == FLAW_PAD && g == groups - 1 && pad > 0) begin
            code = code | 1;
         end
         if (dashed && g != 0 && g % 5 == 0) begin
            text_buf.push_back(CharDash);
         end
         text_buf.push_back(letter_of(code));
      end
      case (flaw)
         FLAW_CHAR: begin
            text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom);
         end
         FLAW_SPACE: begin
            repeat ($urandom_range(1, 20)) begin
               text_buf.insert($urandom_range(0, text_buf.size()), pick_blank());
            end
         end
         FLAW_CUT: begin
            repeat ($urandom_range(1, 3)) begin
               if (text_buf.size() > 1) begin
                  void'(text_buf.pop_back());
               end
            end
         end
         FLAW_NUL: begin
            text_buf.insert($urandom_range(0, text_buf.size() - 1), CharNul);
         end
         default: begin
         end
      endcase
   endtask

   task automatic build_noise_text();
      int r;
      text_buf = {};
      repeat ($urandom_range(1, 70)) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            text_buf.push_back(letter_of($urandom_range(0, 31)));
         end else if (r < 55) begin
            text_buf.push_back(pick_blank());
         end else if (r < 65) begin
            text_buf.push_back(CharDash);
         end else if (r < 70) begin
            text_buf.push_back(CharNul);
         end else begin
            text_buf.push_back(8'($urandom));
         end
      end
   endtask

   initial begin
      int       r;
      int       n_id;
      flaw_type flaw;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_character  <= 8'd0;
      req_final_char <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Shortest well-formed text, then empty, bad and blank-laden texts.
      build_id_text(1, FLAW_NONE);
      send_text();
      text_buf = '{CharNul, "a"};
      send_text();
      text_buf = '{CharDash};
      send_text();
      text_buf = '{8'hFF};
      send_text();
      text_buf = '{8'h09, 8'h20, "7", 8'h80, "Z", 8'h0D};
      send_text();

      random_phase = 1'b1;
      // One identifier a byte too long for the block.
      build_id_text(MaxIdBytes + 1, FLAW_NONE);
      send_text();
      while (chars_sent < CharTarget) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
               n_id = 0;
            end else if (r < 90) begin
               n_id = $urandom_range(1, MaxIdBytes);
            end else begin
               n_id = $urandom_range(MaxIdBytes + 1, 36);
            end
            if ($urandom_range(0, 1) == 0) begin
               flaw = FLAW_NONE;
            end else begin
               flaw = flaw_type'($urandom_range(FLAW_CHAR, FLAW_NUL));
            end
            build_id_text(n_id, flaw);
         end else begin
            build_noise_text();
         end
         send_text();
      end
      req_valid <= 1'b0;

      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      board.check_drained();
      $display("Sent %0d characters in %0d texts; checked %0d results, %0d texts valid.",
               chars_sent, texts_sent, board.checked, board.texts_ok);
      if (board.mismatches == 0) begin
         $display("base32_crc_id_text_decoder_core_tb OK");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("base32_crc_id_text_decoder_core_tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: files.f
src/b32d_pkg.sv
src/b32d_decode.sv
src/b32d_rsp_queue.sv
src/base32_crc_id_text_decoder_core.sv
tb/base32_crc_id_text_decoder_core_tb.sv
